@@ rtl/vitc_pkg.sv @@
// Shared types, widths and constants of the virtual inertia torque command block.
`timescale 1ns / 1ps
package vitc_pkg;

  // Field widths
  localparam int TimeW    = 32;
  localparam int VelW     = 32;
  localparam int OutW     = 32;
  localparam int FracW    = 16;

  // Configuration registers
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 26;
  localparam int GainW    = 16;
  localparam int KtW      = 16;
  localparam int MaxTqW   = 24;
  localparam int MaxCurW  = 24;
  localparam int TfW      = 20;
  localparam int VelDbW   = 24;
  localparam int AccDbW   = 26;
  localparam int CurDbW   = 24;

  localparam logic [CfgIdxW-1:0] RegGain   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegKt     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegMaxTq  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegMaxCur = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegTf     = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegVelDb  = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegAccDb  = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] RegCurDb  = CfgIdxW'(7);

  localparam logic [GainW-1:0]   GainRst   = GainW'(1311);
  localparam logic [KtW-1:0]     KtRst     = KtW'(2294);
  localparam logic [MaxTqW-1:0]  MaxTqRst  = MaxTqW'(327680);
  localparam logic [MaxCurW-1:0] MaxCurRst = MaxCurW'(131072);
  localparam logic [TfW-1:0]     TfRst     = TfW'(15000);
  localparam logic [VelDbW-1:0]  VelDbRst  = VelDbW'(9830);
  localparam logic [AccDbW-1:0]  AccDbRst  = AccDbW'(524288);
  localparam logic [CurDbW-1:0]  CurDbRst  = CurDbW'(1966);

  // Datapath widths
  localparam int DtW    = 14;               // dt after clamping, at most 10000
  localparam int FaW    = 48;               // filtered acceleration, signed
  localparam int DiffW  = FaW + 1;          // signed differences
  localparam int MagW   = DiffW - 1;        // magnitude of a difference
  localparam int TmW    = 64 - FracW;       // product after the Q16.16 shift
  localparam int AluW   = 64;               // shared unit accumulator
  localparam int DivW   = 21;               // divisor / remainder width
  localparam int CntW   = 6;                // step counter

  localparam logic [DtW-1:0]  DtMin  = DtW'(100);
  localparam logic [DtW-1:0]  DtMax  = DtW'(10000);
  localparam logic [DivW-1:0] UsPerS = DivW'(1000000);

  // Step counts of the shared unit, one bit per step
  localparam int NRawBits  = 52;            // |dv| * 1e6 < 2^52
  localparam int NFiltBits = 61;            // |raw - fa| * dt < 2^61
  localparam int NCurBits  = MaxTqW + FracW;

  localparam logic [CntW-1:0] NVel  = CntW'(20);
  localparam logic [CntW-1:0] NRaw  = CntW'(NRawBits);
  localparam logic [CntW-1:0] NMulF = CntW'(DtW);
  localparam logic [CntW-1:0] NFilt = CntW'(NFiltBits);
  localparam logic [CntW-1:0] NTq   = CntW'(GainW);
  localparam logic [CntW-1:0] NCur  = CntW'(NCurBits);

  localparam int RawAlign  = AluW - NRawBits;
  localparam int FiltAlign = AluW - NFiltBits;
  localparam int CurAlign  = AluW - NCurBits;

  typedef enum logic {
    AluMul,
    AluDiv
  } alu_op_e;

  typedef struct packed {
    logic            start;
    alu_op_e         op;
    logic [AluW-1:0] a;
    logic [DivW-1:0] b;
    logic [CntW-1:0] steps;
  } alu_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [AluW-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic [GainW-1:0]   gain;
    logic [KtW-1:0]     kt;
    logic [MaxTqW-1:0]  tq_limit;
    logic [MaxCurW-1:0] cur_limit;
    logic [TfW-1:0]     filter_time;
    logic [VelDbW-1:0]  vel_db;
    logic [AccDbW-1:0]  accel_db;
    logic [CurDbW-1:0]  cur_db;
  } cfg_t;

endpackage

@@ rtl/vitc_if.sv @@
// Handshake channel interfaces: input, result and configuration write.
`timescale 1ns / 1ps
interface vitc_in_if;
  logic                               valid;
  logic                               ready;
  logic        [vitc_pkg::TimeW-1:0]  time_us;
  logic signed [vitc_pkg::VelW-1:0]   velocity;

  modport source (output valid, time_us, velocity, input ready);
  modport sink (input valid, time_us, velocity, output ready);
endinterface

interface vitc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vitc_pkg::OutW-1:0]  current_command;
  logic signed [vitc_pkg::OutW-1:0]  torque_command;

  modport source (output valid, current_command, torque_command, input ready);
  modport sink (input valid, current_command, torque_command, output ready);
endinterface

interface vitc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vitc_pkg::CfgIdxW-1:0]    index;
  logic [vitc_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/vitc_cfg.sv @@
// Configuration register file, written through its own handshake channel.
`timescale 1ns / 1ps
module vitc_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  vitc_cfg_if.sink       cfg_i,
  output vitc_pkg::cfg_t cfg_o
);
  import vitc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        RegGain:   cfg_d.gain        = cfg_i.data[GainW-1:0];
        RegKt:     cfg_d.kt          = cfg_i.data[KtW-1:0];
        RegMaxTq:  cfg_d.tq_limit    = cfg_i.data[MaxTqW-1:0];
        RegMaxCur: cfg_d.cur_limit   = cfg_i.data[MaxCurW-1:0];
        RegTf:     cfg_d.filter_time = cfg_i.data[TfW-1:0];
        RegVelDb:  cfg_d.vel_db      = cfg_i.data[VelDbW-1:0];
        RegAccDb:  cfg_d.accel_db    = cfg_i.data[AccDbW-1:0];
        RegCurDb:  cfg_d.cur_db      = cfg_i.data[CurDbW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain        <= GainRst;
      cfg_q.kt          <= KtRst;
      cfg_q.tq_limit    <= MaxTqRst;
      cfg_q.cur_limit   <= MaxCurRst;
      cfg_q.filter_time <= TfRst;
      cfg_q.vel_db      <= VelDbRst;
      cfg_q.accel_db    <= AccDbRst;
      cfg_q.cur_db      <= CurDbRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/vitc_alu.sv @@
// Shared bit-serial unit: shift-add multiplier and restoring divider.
`timescale 1ns / 1ps
module vitc_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vitc_pkg::alu_req_t req_i,
  output vitc_pkg::alu_rsp_t rsp_o
);
  import vitc_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  alu_op_e         op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AluW-1:0] acc_q, acc_d;
  logic [AluW-1:0] sh_q, sh_d;
  logic [DivW-1:0] b_q, b_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW:0]   trial;
  logic [DivW:0]   trial_sub;
  logic            fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign trial     = {rem_q, sh_q[AluW-1]};
  assign trial_sub = trial - {1'b0, b_q};
  assign fits      = (trial >= {1'b0, b_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    b_d    = b_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = req_i.steps;
      acc_d  = '0;
      sh_d   = req_i.a;
      b_d    = req_i.b;
      rem_d  = '0;
    end else if (busy_q) begin
      if (op_q == AluMul) begin
        if (b_q[0]) begin
          acc_d = acc_q + sh_q;
        end
        sh_d = {sh_q[AluW-2:0], 1'b0};
        b_d  = {1'b0, b_q[DivW-1:1]};
      end else begin
        rem_d = fits ? trial_sub[DivW-1:0] : trial[DivW-1:0];
        sh_d  = {sh_q[AluW-2:0], fits};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= AluMul;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
    rem_q <= rem_d;
  end

  // The quotient collects in the low bits of the shift register.
  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == AluDiv) ? sh_q : acc_q;

endmodule

@@ rtl/virtual_inertia_torque_command_core.sv @@
// Virtual inertia torque command: sequencer and datapath around one shared mul/div unit.
// Only one input transaction is in flight: input is taken only while idle, and a stalled
//   output holds the result back. The first transaction after reset only primes the stored
//   time and velocity. The shared bit-serial unit runs 20 + 52 + 14 + 61 + 16 + 40
//   single-bit steps per item.
// Reset: asynchronous, active low; config returns to defaults, filter state clears.
`timescale 1ns / 1ps
module virtual_inertia_torque_command_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  vitc_in_if.sink    in_i,
  vitc_out_if.source out_o,
  vitc_cfg_if.sink   cfg_i
);
  import vitc_pkg::*;

  // Sequencer codes
  localparam logic [3:0] StIdle = 4'd0;   // wait for an input transaction
  localparam logic [3:0] StPrep = 4'd1;   // dt clamp, velocity deadband
  localparam logic [3:0] StDiff = 4'd2;   // velocity difference
  localparam logic [3:0] StMulV = 4'd3;   // |dv| * 1e6
  localparam logic [3:0] StDivV = 4'd4;   // / dt -> raw acceleration
  localparam logic [3:0] StSubF = 4'd5;   // raw - filtered
  localparam logic [3:0] StMulF = 4'd6;   // * dt
  localparam logic [3:0] StDivF = 4'd7;   // / (Tf + dt), accumulate
  localparam logic [3:0] StFaDb = 4'd8;   // acceleration deadband
  localparam logic [3:0] StMulT = 4'd9;   // |fa| * inertia gain
  localparam logic [3:0] StDivC = 4'd10;  // torque / Kt
  localparam logic [3:0] StFin  = 4'd11;  // hand result to the output register

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [3:0] state_q, state_d;
  logic       issued_q, issued_d;
  logic       primed_q, primed_d;

  // Model state
  logic        [TimeW-1:0] prev_time_q, prev_time_d;
  logic signed [VelW-1:0]  prev_vel_q, prev_vel_d;
  logic signed [FaW-1:0]   fa_q, fa_d;

  // Working registers
  logic        [TimeW-1:0]  time_q, time_d;
  logic signed [VelW-1:0]   vel_q, vel_d;
  logic        [DtW-1:0]    dt_q, dt_d;
  logic signed [DiffW-1:0]  diff_q, diff_d;
  logic                     neg_q, neg_d;
  logic signed [FaW-1:0]    raw_q, raw_d;
  logic        [MaxTqW-1:0] tmag_q, tmag_d;
  logic signed [OutW-1:0]   torque_q, torque_d;
  logic signed [OutW-1:0]   cur_q, cur_d;

  // Result register
  logic                   out_valid_q, out_valid_d;
  logic signed [OutW-1:0] out_cur_q, out_cur_d;
  logic signed [OutW-1:0] out_tq_q, out_tq_d;

  // Helpers
  logic [TimeW-1:0]   dt_wrap;
  logic [DtW-1:0]     dt_clamp;
  logic [VelW-1:0]    vel_mag;
  logic [MagW-1:0]    diff_mag;
  logic [FaW-1:0]     fa_mag;
  logic [FaW-1:0]     quot;
  logic [TmW-1:0]     tm_full;
  logic [MaxTqW-1:0]  tm_sat;
  logic [OutW-1:0]    tm_ext;
  logic [NCurBits-1:0] cq_full;
  logic [MaxCurW-1:0] cq_clamp;
  logic [MaxCurW-1:0] cq_sat;
  logic [OutW-1:0]    cq_ext;
  logic [KtW-1:0]     kt_eff;
  logic [OutW-1:0]    out_tq_mag;
  logic               in_fire;

  vitc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  vitc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && (state_q == StIdle);

  // dt wraps modulo 2^32, then clamps to the 100..10000 us window
  assign dt_wrap  = time_q - prev_time_q;
  assign dt_clamp = (dt_wrap < TimeW'(DtMin)) ? DtMin :
                    (dt_wrap > TimeW'(DtMax)) ? DtMax : dt_wrap[DtW-1:0];

  // Magnitudes; the most negative velocity maps to 2^31 as unsigned
  assign vel_mag  = vel_q[VelW-1] ? VelW'(-vel_q) : VelW'(vel_q);
  assign diff_mag = diff_q[DiffW-1] ? MagW'(-diff_q) : MagW'(diff_q);
  assign fa_mag   = fa_q[FaW-1] ? FaW'(-fa_q) : FaW'(fa_q);

  // Quotients of the first two divides stay below 2^47
  assign quot     = alu_rsp.result[FaW-1:0];

  // Torque magnitude: drop Q16.16 fraction bits, clamp to max torque
  assign tm_full  = alu_rsp.result[AluW-1:FracW];
  assign tm_sat   = (tm_full > TmW'(cfg.tq_limit)) ? cfg.tq_limit : tm_full[MaxTqW-1:0];
  assign tm_ext   = OutW'(tm_sat);

  // Current magnitude: clamp to max current, then deadband
  assign cq_full  = alu_rsp.result[NCurBits-1:0];
  assign cq_clamp = (cq_full > NCurBits'(cfg.cur_limit)) ? cfg.cur_limit :
                    cq_full[MaxCurW-1:0];
  assign cq_sat   = (cq_clamp < cfg.cur_db) ? '0 : cq_clamp;
  assign cq_ext   = OutW'(cq_sat);

  // A zero torque constant counts as one
  assign kt_eff   = (cfg.kt == '0) ? KtW'(1) : cfg.kt;

  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    primed_d    = primed_q;
    prev_time_d = prev_time_q;
    prev_vel_d  = prev_vel_q;
    fa_d        = fa_q;
    time_d      = time_q;
    vel_d       = vel_q;
    dt_d        = dt_q;
    diff_d      = diff_q;
    neg_d       = neg_q;
    raw_d       = raw_q;
    tmag_d      = tmag_q;
    torque_d    = torque_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_cur_d   = out_cur_q;
    out_tq_d    = out_tq_q;
    alu_req     = '0;

    // Drop the result once the sink takes it
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          time_d = in_i.time_us;
          vel_d  = in_i.velocity;
          if (!primed_q) begin
            // Priming transaction: store raw values, report zeros
            primed_d    = 1'b1;
            prev_time_d = in_i.time_us;
            prev_vel_d  = in_i.velocity;
            cur_d       = '0;
            torque_d    = '0;
            state_d     = StFin;
          end else begin
            state_d = StPrep;
          end
        end
      end
      StPrep: begin
        dt_d        = dt_clamp;
        prev_time_d = time_q;
        if (vel_mag < VelW'(cfg.vel_db)) begin
          vel_d = '0;
        end
        state_d = StDiff;
      end
      StDiff: begin
        diff_d     = DiffW'(vel_q) - DiffW'(prev_vel_q);
        prev_vel_d = vel_q;
        state_d    = StMulV;
      end
      StMulV: begin
        if (!issued_q) begin
          alu_req.start = 1'b1;
          alu_req.op    = AluMul;
          alu_req.a     = AluW'(diff_mag);
          alu_req.b     = UsPerS;
          alu_req.steps = NVel;
          neg_d         = diff_q[DiffW-1];
          issued_d      = 1'b1;
        end else if (alu_rsp.done) begin
          issued_d = 1'b0;
          state_d  = StDivV;
        end
      end
      StDivV: begin
        if (!issued_q) begin
          alu_req.start = 1'b1;
          alu_req.op    = AluDiv;
          alu_req.a     = alu_rsp.result << RawAlign;
          alu_req.b     = DivW'(dt_q);
          alu_req.steps = NRaw;
          issued_d      = 1'b1;
        end else if (alu_rsp.done) begin
          // Truncate toward zero: divide magnitudes, restore the sign
          raw_d    = neg_q ? -$signed(quot) : $signed(quot);
          issued_d = 1'b0;
          state_d  = StSubF;
        end
      end
      StSubF: begin
        diff_d  = DiffW'(raw_q) - DiffW'(fa_q);
        state_d = StMulF;
      end
      StMulF: begin
        if (!issued_q) begin
          alu_req.start = 1'b1;
          alu_req.op    = AluMul;
          alu_req.a     = AluW'(diff_mag);
          alu_req.b     = DivW'(dt_q);
          alu_req.steps = NMulF;
          neg_d         = diff_q[DiffW-1];
          issued_d      = 1'b1;
        end else if (alu_rsp.done) begin
          issued_d = 1'b0;
          state_d  = StDivF;
        end
      end
      StDivF: begin
        if (!issued_q) begin
          alu_req.start = 1'b1;
          alu_req.op    = AluDiv;
          alu_req.a     = alu_rsp.result << FiltAlign;
          alu_req.b     = DivW'(cfg.filter_time) + DivW'(dt_q);
          alu_req.steps = NFilt;
          issued_d      = 1'b1;
        end else if (alu_rsp.done) begin
          // Gain is at most one, so the sum stays within 48 bits
          fa_d     = neg_q ? fa_q - $signed(quot) : fa_q + $signed(quot);
          issued_d = 1'b0;
          state_d  = StFaDb;
        end
      end
      StFaDb: begin
        if (fa_mag < FaW'(cfg.accel_db)) begin
          fa_d = '0;
        end
        state_d = StMulT;
      end
      StMulT: begin
        if (!issued_q) begin
          alu_req.start = 1'b1;
          alu_req.op    = AluMul;
          alu_req.a     = AluW'(fa_mag);
          alu_req.b     = DivW'(cfg.gain);
          alu_req.steps = NTq;
          // Torque opposes a positive acceleration
          neg_d         = !fa_q[FaW-1] && (fa_q != '0);
          issued_d      = 1'b1;
        end else if (alu_rsp.done) begin
          tmag_d   = tm_sat;
          torque_d = neg_q ? -$signed(tm_ext) : $signed(tm_ext);
          issued_d = 1'b0;
          state_d  = StDivC;
        end
      end
      StDivC: begin
        if (!issued_q) begin
          alu_req.start = 1'b1;
          alu_req.op    = AluDiv;
          alu_req.a     = AluW'({tmag_q, FracW'(0)}) << CurAlign;
          alu_req.b     = DivW'(kt_eff);
          alu_req.steps = NCur;
          issued_d      = 1'b1;
        end else if (alu_rsp.done) begin
          cur_d    = neg_q ? -$signed(cq_ext) : $signed(cq_ext);
          issued_d = 1'b0;
          state_d  = StFin;
        end
      end
      StFin: begin
        // Hold until the result register is free or drains this cycle
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_cur_d   = cur_q;
          out_tq_d    = torque_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d  = StIdle;
        issued_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      issued_q    <= 1'b0;
      primed_q    <= 1'b0;
      prev_time_q <= '0;
      prev_vel_q  <= '0;
      fa_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      primed_q    <= primed_d;
      prev_time_q <= prev_time_d;
      prev_vel_q  <= prev_vel_d;
      fa_q        <= fa_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q    <= time_d;
    vel_q     <= vel_d;
    dt_q      <= dt_d;
    diff_q    <= diff_d;
    neg_q     <= neg_d;
    raw_q     <= raw_d;
    tmag_q    <= tmag_d;
    torque_q  <= torque_d;
    cur_q     <= cur_d;
    out_cur_q <= out_cur_d;
    out_tq_q  <= out_tq_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.current_command = out_cur_q;
  assign out_o.torque_command  = out_tq_q;

  assign out_tq_mag = out_tq_q[OutW-1] ? OutW'(-out_tq_q) : OutW'(out_tq_q);

  // Never start the shared unit while it still iterates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit restarted while busy");

  // An input transaction leads to either the priming path or the full computation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == StPrep || state_q == StFin))
    else $error("unexpected sequencer step after input transaction");

  // A pending torque result stays within the torque clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_tq_mag <= OutW'(cfg.tq_limit)))
    else $error("torque result exceeds max torque");

  // A nonzero current follows a nonzero torque of the same sign
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_cur_q != '0)) |->
      ((out_tq_q != '0) && (out_cur_q[OutW-1] == out_tq_q[OutW-1])))
    else $error("current sign disagrees with torque");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the virtual inertia torque command core.
`timescale 1ns / 1ps
module testbench;
  import vitc_pkg::*;

  localparam int    IdlePct    = 16;         // chance in a hundred that a side idles
  localparam int    HoldCycles = 2000;       // long receiver hold-off, fills the block
  localparam int    SettleWait = 500;        // quiet cycles at the end, above the latency
  localparam int    MaxReports = 10;
  localparam longint CycleLimit = 3_000_000;

  // Kinds of entries in the stimulus queue
  typedef enum logic [1:0] {
    EntTick,
    EntCfg,
    EntDrain,
    EntHoldOff
  } entry_kind_e;

  // Register settings applied between phases
  typedef enum logic [2:0] {
    SetZero,
    SetOnes,
    SetReset,
    SetRandom,
    SetLively,
    SetNoKt
  } setting_e;

  typedef struct packed {
    entry_kind_e         kind;
    logic                calm;
    logic [TimeW-1:0]    time_us;
    logic [VelW-1:0]     velocity;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } stim_entry_t;

  typedef struct packed {
    logic [OutW-1:0] current;
    logic [OutW-1:0] torque;
  } cmd_t;

  logic clk_i;
  logic rst_ni;

  vitc_in_if  in_if ();
  vitc_out_if out_if ();
  vitc_cfg_if cfg_if ();

  virtual_inertia_torque_command_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Stimulus queue, filled up front and drained by the driver.
  stim_entry_t tick_q[$];
  // Expected commands, oldest first.
  cmd_t        cmd_q[$];

  stim_entry_t cur;          // entry the driver is working on
  logic        pending;      // cur still waits for its transaction
  logic        calm;         // no idling on either side while set
  logic        hold_req;     // one-cycle request for the long receiver hold-off
  int          hold_cnt;
  longint      cycle_cnt;

  int ticks_sent;
  int writes_done;
  int results_seen;
  int nonzero_current;
  int nonzero_torque;
  int mismatch_cnt;

  // Predictor state: a private copy of the block's registers and filter.
  cfg_t         model_cfg;
  longint       vel_prev;
  longint       accel_filt;
  logic [31:0]  time_prev;
  logic         primed;

  logic [TimeW-1:0]       gen_time;
  logic signed [VelW-1:0] gen_vel;

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------

  function automatic longint abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Mirror a register write; the data is cut to the register's width.
  function automatic void apply_setting(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] d);
    case (idx)
      RegGain:   model_cfg.gain        = d[GainW-1:0];
      RegKt:     model_cfg.kt          = d[KtW-1:0];
      RegMaxTq:  model_cfg.tq_limit    = d[MaxTqW-1:0];
      RegMaxCur: model_cfg.cur_limit   = d[MaxCurW-1:0];
      RegTf:     model_cfg.filter_time = d[TfW-1:0];
      RegVelDb:  model_cfg.vel_db      = d[VelDbW-1:0];
      RegAccDb:  model_cfg.accel_db    = d[AccDbW-1:0];
      RegCurDb:  model_cfg.cur_db      = d[CurDbW-1:0];
      default: ;
    endcase
  endfunction

  // Advance the filter by one control tick and work out the command it yields.
  function automatic void predict_command(input logic [TimeW-1:0] t,
                                          input logic signed [VelW-1:0] v,
                                          output cmd_t r);
    logic [31:0]     gap;
    longint          dt;
    longint          vel;
    longint          raw;
    longint          tmag;
    longint          cmag;
    longint          torque;
    longint          cur_cmd;
    longint unsigned prod;
    longint unsigned kt;
    // First tick after reset only latches time and raw velocity.
    if (!primed) begin
      primed    = 1'b1;
      time_prev = t;
      vel_prev  = longint'(v);
      r         = '0;
      return;
    end

    // Elapsed time wraps modulo 2^32, then is clamped to the valid range.
    gap       = t - time_prev;
    time_prev = t;
    dt        = longint'(gap);
    if (dt < longint'(DtMin)) dt = longint'(DtMin);
    if (dt > longint'(DtMax)) dt = longint'(DtMax);

    vel = longint'(v);
    if (abs64(vel) < longint'(model_cfg.vel_db)) vel = 0;

    raw      = (vel - vel_prev) * longint'(UsPerS) / dt;
    vel_prev = vel;

    accel_filt = accel_filt + (raw - accel_filt) * dt
                 / (longint'(model_cfg.filter_time) + dt);
    if (abs64(accel_filt) < longint'(model_cfg.accel_db)) accel_filt = 0;

    // Torque opposes the acceleration.
    prod = abs64(accel_filt);
    prod = (prod * model_cfg.gain) >> FracW;
    tmag = longint'(prod);
    if (tmag > longint'(model_cfg.tq_limit)) tmag = longint'(model_cfg.tq_limit);
    torque = (accel_filt > 0) ? -tmag : tmag;

    // A zero torque constant acts as the smallest nonzero one.
    kt   = (model_cfg.kt == '0) ? 64'd1 : 64'(model_cfg.kt);
    prod = tmag;
    prod = (prod << FracW) / kt;
    cmag = longint'(prod);
    if (cmag > longint'(model_cfg.cur_limit)) cmag = longint'(model_cfg.cur_limit);
    if (cmag < longint'(model_cfg.cur_db)) cmag = 0;
    cur_cmd = (torque < 0) ? -cmag : cmag;

    r.current = cur_cmd[OutW-1:0];
    r.torque  = torque[OutW-1:0];
  endfunction

  // ------------------------------------------------------------------
  // Stimulus building
  // ------------------------------------------------------------------

  task automatic push_tick(input logic [TimeW-1:0] t, input logic [VelW-1:0] v,
                           input logic c);
    stim_entry_t e;
    e          = '0;
    e.kind     = EntTick;
    e.calm     = c;
    e.time_us  = t;
    e.velocity = v;
    tick_q.push_back(e);
  endtask

  task automatic push_entry(input entry_kind_e k, input logic [CfgIdxW-1:0] idx,
                            input logic [CfgDataW-1:0] d);
    stim_entry_t e;
    e       = '0;
    e.kind  = k;
    e.index = idx;
    e.data  = d;
    tick_q.push_back(e);
  endtask

  // Random value within a register's width, often with the top bits cleared.
  function automatic logic [CfgDataW-1:0] rand_field(input int w);
    logic [31:0] x;
    x = $urandom & ((32'd1 << w) - 1);
    return CfgDataW'(x >> $urandom_range(0, w - 1));
  endfunction

  // Wait for the block to go idle, then write every register.
  task automatic load_setting(input setting_e mode);
    logic [CfgDataW-1:0] g, k, mt, mc, tf, vd, ad, cd;
    case (mode)
      SetZero: begin
        g = '0; k = '0; mt = '0; mc = '0; tf = '0; vd = '0; ad = '0; cd = '0;
      end
      SetOnes: begin
        // All 26 data bits set: the upper bits must be dropped per register.
        g = '1; k = '1; mt = '1; mc = '1; tf = '1; vd = '1; ad = '1; cd = '1;
      end
      SetReset: begin
        g  = CfgDataW'(GainRst);   k  = CfgDataW'(KtRst);
        mt = CfgDataW'(MaxTqRst);  mc = CfgDataW'(MaxCurRst);
        tf = CfgDataW'(TfRst);     vd = CfgDataW'(VelDbRst);
        ad = CfgDataW'(AccDbRst);  cd = CfgDataW'(CurDbRst);
      end
      SetLively: begin
        // Small deadbands and a short filter so commands move a lot.
        g  = CfgDataW'($urandom_range(500, 65535));
        k  = CfgDataW'($urandom_range(200, 65535));
        mt = CfgDataW'($urandom_range(1 << 16, (1 << 24) - 1));
        mc = CfgDataW'($urandom_range(1 << 14, (1 << 24) - 1));
        tf = CfgDataW'($urandom_range(0, 40000));
        vd = CfgDataW'($urandom_range(0, 20000));
        ad = CfgDataW'($urandom_range(0, 1 << 20));
        cd = CfgDataW'($urandom_range(0, 8192));
      end
      default: begin
        g  = rand_field(GainW);   k  = rand_field(KtW);
        mt = rand_field(MaxTqW);  mc = rand_field(MaxCurW);
        tf = rand_field(TfW);     vd = rand_field(VelDbW);
        ad = rand_field(AccDbW);  cd = rand_field(CurDbW);
      end
    endcase
    if (mode == SetNoKt) k = '0;

    push_entry(EntDrain, RegGain, '0);
    push_entry(EntCfg, RegGain,   g);
    push_entry(EntCfg, RegKt,     k);
    push_entry(EntCfg, RegMaxTq,  mt);
    push_entry(EntCfg, RegMaxCur, mc);
    push_entry(EntCfg, RegTf,     tf);
    push_entry(EntCfg, RegVelDb,  vd);
    push_entry(EntCfg, RegAccDb,  ad);
    push_entry(EntCfg, RegCurDb,  cd);
  endtask

  // Mostly a smooth velocity walk at sane tick spacing, with jumps,
  // deadband-sized values and odd time gaps mixed in.
  task automatic add_random_ticks(input int n, input logic c);
    int          sel;
    logic [31:0] step;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 70)      step = $urandom_range(100, 10000);
      else if (sel < 80) step = $urandom_range(0, 99);
      else if (sel < 92) step = $urandom_range(10001, 300000);
      else               step = $urandom;
      gen_time += step;

      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        gen_vel += $signed($urandom) >>> $urandom_range(4, 31);
      end else if (sel < 85) begin
        gen_vel = $urandom_range(0, 20000);
        if ($urandom_range(0, 1)) gen_vel = -gen_vel;
      end else if (sel < 92) begin
        gen_vel = gen_vel;   // hold speed, let the filter decay
      end else begin
        gen_vel = $urandom;
      end
      push_tick(gen_time, gen_vel, c);
    end
  endtask

  // ------------------------------------------------------------------
  // Clock and reset
  // ------------------------------------------------------------------

  always #2 clk_i = ~clk_i;

  // ------------------------------------------------------------------
  // Driver: one entry at a time from the stimulus queue
  // ------------------------------------------------------------------

  always @(posedge clk_i) begin
    stim_entry_t head;
    cmd_t        want;
    logic        offer_tick;
    logic        offer_cfg;
    logic        hold_now;
    if (rst_ni) begin
      hold_now = 1'b0;

      // Record completed transactions first, so the queue reflects this edge.
      if (in_if.valid && in_if.ready) begin
        predict_command(cur.time_us, cur.velocity, want);
        cmd_q.push_back(want);
        ticks_sent++;
        pending = 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        apply_setting(cur.index, cur.data);
        writes_done++;
        pending = 1'b0;
      end

      // Fetch the next entry. A drain marker holds until every command is back.
      if (!pending && tick_q.size() != 0) begin
        head = tick_q[0];
        case (head.kind)
          EntDrain: begin
            if (cmd_q.size() == 0) void'(tick_q.pop_front());
          end
          EntHoldOff: begin
            hold_now = 1'b1;
            void'(tick_q.pop_front());
          end
          default: begin
            cur     = tick_q.pop_front();
            pending = 1'b1;
            calm    = head.calm;
          end
        endcase
      end

      // Keep an offered tick up until it is taken; otherwise idle at random.
      offer_tick = pending && cur.kind == EntTick &&
                   ((in_if.valid && !in_if.ready) || calm ||
                    $urandom_range(0, 99) >= IdlePct);
      offer_cfg  = pending && cur.kind == EntCfg;

      in_if.valid    <= offer_tick;
      in_if.time_us  <= cur.time_us;
      in_if.velocity <= cur.velocity;
      cfg_if.valid   <= offer_cfg;
      cfg_if.index   <= cur.index;
      cfg_if.data    <= cur.data;
      hold_req       <= hold_now;
    end
  end

  // Count down the long receiver hold-off.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_cnt <= HoldCycles;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: check each command against the oldest expectation
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what, input cmd_t want, input cmd_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports)
      $display("[%0t] %s: current exp %0d got %0d, torque exp %0d got %0d",
               $realtime, what, $signed(want.current), $signed(got.current),
               $signed(want.torque), $signed(got.torque));
  endtask

  always @(posedge clk_i) begin
    cmd_t want;
    cmd_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.current = out_if.current_command;
        got.torque  = out_if.torque_command;
        results_seen++;
        if (got.current != '0) nonzero_current++;
        if (got.torque != '0) nonzero_torque++;
        if (cmd_q.size() == 0) begin
          report_mismatch("command with no tick pending", '0, got);
        end else begin
          want = cmd_q.pop_front();
          if (want.current !== got.current || want.torque !== got.torque)
            report_mismatch("command mismatch", want, got);
        end
      end
      out_if.ready <= hold_cnt == 0 && (calm || $urandom_range(0, 99) >= IdlePct);
    end
  end

  // Drop the run if it stops making progress.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d commands outstanding",
               cycle_cnt, cmd_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin
    logic [TimeW-1:0] t;

    // Known values on every input from time zero.
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.time_us   = '0;
    in_if.velocity  = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = RegGain;
    cfg_if.data     = '0;
    cur             = '0;
    pending         = 1'b0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    hold_cnt        = 0;
    cycle_cnt       = 0;
    ticks_sent      = 0;
    writes_done     = 0;
    results_seen    = 0;
    nonzero_current = 0;
    nonzero_torque  = 0;
    mismatch_cnt    = 0;

    // Predictor starts from the reset state of the block.
    model_cfg.gain        = GainRst;
    model_cfg.kt          = KtRst;
    model_cfg.tq_limit    = MaxTqRst;
    model_cfg.cur_limit   = MaxCurRst;
    model_cfg.filter_time = TfRst;
    model_cfg.vel_db      = VelDbRst;
    model_cfg.accel_db    = AccDbRst;
    model_cfg.cur_db      = CurDbRst;
    vel_prev   = 0;
    accel_filt = 0;
    time_prev  = '0;
    primed     = 1'b0;

    // Directed ticks under the reset settings.
    t = 32'hFFFF_FF00;
    push_tick(t, 32'h7FFF_FFFF, 1'b0);          // priming tick, full-scale speed
    t += 32'h1000;                              // timestamp wraps past zero
    push_tick(t, 32'h7FFF_FFFF, 1'b0);
    t += 50;                                    // gap below the minimum
    push_tick(t, 32'h8000_0000, 1'b0);          // full reversal, clamps saturate
    t += 20000;                                 // gap above the maximum
    push_tick(t, '0, 1'b0);
    t += 1000;
    push_tick(t, 32'd9829, 1'b0);               // just inside velocity deadband
    t += 1000;
    push_tick(t, -32'sd9830, 1'b0);             // exactly on the deadband edge
    t += 1000;
    push_tick(t, -32'sd9829, 1'b0);
    t += 1000;
    push_tick(t, 32'h0001_0000, 1'b0);          // unit step in speed
    push_tick(t, 32'h0001_0000, 1'b0);          // repeated timestamp
    repeat (4) begin
      t += 1000;
      push_tick(t, 32'h0001_0000, 1'b0);        // steady speed, filter decays
    end
    t += 32'hFFFF_FFFF;                         // clock steps back by one
    push_tick(t, 32'h0000_0100, 1'b0);
    t += 100;
    push_tick(t, 32'hFFFF_FF00, 1'b0);
    t += 10000;
    push_tick(t, 32'h7FFF_0000, 1'b0);
    t += 10001;
    push_tick(t, 32'h00FF_00FF, 1'b0);
    t += 99;
    push_tick(t, '0, 1'b0);
    push_tick('0, '0, 1'b0);
    push_tick('1, '1, 1'b0);

    gen_time = '1;
    gen_vel  = '1;

    // Random phases, each under a fresh register setting.
    load_setting(SetOnes);
    add_random_ticks(100, 1'b0);
    load_setting(SetZero);
    add_random_ticks(100, 1'b0);
    load_setting(SetLively);
    add_random_ticks(200, 1'b1);                // no idling on either side
    load_setting(SetRandom);
    push_entry(EntHoldOff, RegGain, '0);        // receiver backs off, block fills
    add_random_ticks(200, 1'b0);
    load_setting(SetReset);
    add_random_ticks(150, 1'b0);
    load_setting(SetNoKt);
    add_random_ticks(150, 1'b0);
    load_setting(SetLively);
    add_random_ticks(330, 1'b0);

    // Release reset away from the active edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all stimulus to go out and every command to come back.
    while (tick_q.size() != 0 || pending || cmd_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);

    $display("Covered %0d ticks and %0d register writes over 7 settings; %0d commands.",
             ticks_sent, writes_done, results_seen);
    $display("Nonzero current in %0d commands, nonzero torque in %0d; %0d mismatches.",
             nonzero_current, nonzero_torque, mismatch_cnt);
    if (mismatch_cnt == 0 && cmd_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
